// File: design/rcps_pkg.sv
// rcps_pkg: shared types, codes and the collision mask lookup
package rcps_pkg;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_MOVE = 2'd1,
    OP_MARK = 2'd2,
    OP_TICK = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    RK_ADDED = 3'd0,
    RK_FULL  = 3'd1,
    RK_ACK   = 3'd2,
    RK_HIT   = 3'd3,
    RK_DONE  = 3'd4
  } result_kind_t;

  localparam int MASK_W    = 50;
  localparam int NUM_TYPES = 10;
  localparam int HALF_ROWS = 5;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } rect_t;

  typedef struct packed {
    logic [3:0] kind;
    logic       lis;
  } attr_t;

  // one classified command as it travels from front to back
  typedef struct packed {
    opcode_t    op;
    logic [2:0] slot;
    logic       slot_ok;
    rect_t      rect;
    attr_t      attr;
  } cmd_t;

  // mask[row][col]; any type above nine reads as zero
  function automatic logic mask_bit(input logic [MASK_W-1:0] low,
                                    input logic [MASK_W-1:0] high,
                                    input logic [3:0] row,
                                    input logic [3:0] col);
    logic [5:0] idx;
    logic       res;
    idx = 6'd0;
    res = 1'b0;
    if (row < 4'(NUM_TYPES) && col < 4'(NUM_TYPES)) begin
      if (row < 4'(HALF_ROWS)) begin
        idx = 6'(row * 6'd10) + 6'(col);
        res = low[idx];
      end else begin
        idx = 6'((row - 4'(HALF_ROWS)) * 6'd10) + 6'(col);
        res = high[idx];
      end
    end
    return res;
  endfunction

endpackage

// File: design/rcps_if.sv
// rcps_if: input and result channel interfaces
interface rcps_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [2:0]         slot;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic [14:0]        rect_w;
  logic [14:0]        rect_h;
  logic [3:0]         rect_class;
  logic               has_listener;

  modport source (output valid, opcode, slot, rect_x, rect_y, rect_w, rect_h,
                  rect_class, has_listener, input ready);
  modport sink (input valid, opcode, slot, rect_x, rect_y, rect_w, rect_h,
                rect_class, has_listener, output ready);
endinterface

interface rcps_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [2:0] self_slot;
  logic [2:0] other_slot;
  logic [3:0] live_count;
  logic       last;

  modport source (output valid, result_kind, self_slot, other_slot, live_count, last,
                  input ready);
  modport sink (input valid, result_kind, self_slot, other_slot, live_count, last,
                output ready);
endinterface

// File: design/rect_collision_pair_scanner.sv
// rect_collision_pair_scanner: top level with mask registers and APB port
// Rectangle collision table of SLOTS slots. Add, move and mark beats are
// each handled in the back end while it is idle and give one result beat.
// A frame tick first frees marked slots, then walks the pairs i<k: a pair
// with an empty slot is skipped; an occupied pair takes a registered slot
// memory read, then the overlap test, and a second report state when both
// slots report. The walk then closes and the frame-done beat is sent. Any
// stall of the result channel holds the scan.
// The two 50-bit mask registers sit at byte addresses 0 and 8 and must be
// written only while the block is idle. A short command queue decouples
// the input from the scan, and an output register decouples the results.
module rect_collision_pair_scanner
  import rcps_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  rcps_in_if.sink     in_ch,
  rcps_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [MASK_W-1:0] mask_low_r, mask_high_r;
  logic              cfg_we;
  logic              push, full, qvalid, pop;
  cmd_t              push_data, pop_data;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = cfg_paddr[3] ? 64'(mask_high_r) : 64'(mask_low_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_low_r  <= '0;
      mask_high_r <= '0;
    end else if (cfg_we) begin
      if (cfg_paddr[3]) begin
        mask_high_r <= cfg_pwdata[MASK_W-1:0];
      end else begin
        mask_low_r <= cfg_pwdata[MASK_W-1:0];
      end
    end
  end

  rcps_front #(.SLOTS(SLOTS)) u_front (
    .in_ch    (in_ch),
    .cmd_push (push),
    .cmd_data (push_data),
    .cmd_full (full)
  );

  rcps_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop_valid (qvalid),
    .pop_data  (pop_data),
    .pop       (pop)
  );

  rcps_back #(.SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (qvalid),
    .cmd       (pop_data),
    .cmd_pop   (pop),
    .mask_low  (mask_low_r),
    .mask_high (mask_high_r),
    .out_ch    (out_ch)
  );

endmodule

// File: design/rcps_front.sv
// rcps_front: accepts input beats and classifies them into commands
module rcps_front
  import rcps_pkg::*;
#(
  parameter int SLOTS = 8
) (
  rcps_in_if.sink     in_ch,
  output logic        cmd_push,
  output cmd_t        cmd_data,
  input  logic        cmd_full
);

  // accept whenever the queue has room
  assign in_ch.ready = !cmd_full;
  assign cmd_push    = in_ch.valid && !cmd_full;

  // decode and range check the slot
  always_comb begin
    cmd_data.op        = opcode_t'(in_ch.opcode);
    cmd_data.slot      = in_ch.slot;
    cmd_data.slot_ok   = ({1'b0, in_ch.slot} < 4'(SLOTS));
    cmd_data.rect.x    = in_ch.rect_x;
    cmd_data.rect.y    = in_ch.rect_y;
    cmd_data.rect.w    = in_ch.rect_w;
    cmd_data.rect.h    = in_ch.rect_h;
    cmd_data.attr.kind = in_ch.rect_class;
    cmd_data.attr.lis  = in_ch.has_listener;
  end

endmodule

// File: design/rcps_cmdq.sv
// rcps_cmdq: two-entry command queue between front and back
module rcps_cmdq
  import rcps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  output logic pop_valid,
  output cmd_t pop_data,
  input  logic pop
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  // pointer and fill updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/rcps_back.sv
// rcps_back: slot table, pair scan and result register
module rcps_back
  import rcps_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  input  logic [MASK_W-1:0] mask_low,
  input  logic [MASK_W-1:0] mask_high,
  rcps_out_if.source        out_ch
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_EVAL, S_SECOND, S_DONE} state_t;

  state_t         state_r;
  logic [SLOTS-1:0] valid_r, mark_r;
  logic [3:0]     count_r;
  logic [IW-1:0]  i_r, k_r;

  result_kind_t   kind_r;
  logic           ovalid_r;
  logic [2:0]     self_r, other_r;
  logic [3:0]     live_r;
  logic           last_r;

  rect_t          rect_mem [SLOTS];
  attr_t          attr_mem [SLOTS];
  rect_t          rect_a_r, rect_b_r;
  attr_t          attr_a_r, attr_b_r;

  logic           out_free;
  logic           found;
  logic [IW-1:0]  free_idx;
  logic [IW-1:0]  tgt;
  logic [3:0]     freed;
  logic [SLOTS-1:0] drop;
  logic           rect_we, attr_we;
  logic [IW-1:0]  wa;
  logic           issue;
  logic           ov, rep_a, rep_b;
  logic signed [17:0] a_r, a_l, a_b, a_t, b_r, b_l, b_b, b_t;
  logic           pair_end;

  assign out_ch.valid       = ovalid_r;
  assign out_ch.result_kind = kind_r;
  assign out_ch.self_slot   = self_r;
  assign out_ch.other_slot  = other_r;
  assign out_ch.live_count  = live_r;
  assign out_ch.last        = last_r;

  assign out_free = !ovalid_r || out_ch.ready;
  assign issue    = (state_r == S_IDLE) && cmd_valid && out_free;
  assign tgt      = cmd.slot[IW-1:0];

  // first free slot
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!valid_r[s]) begin
        found    = 1'b1;
        free_idx = IW'(s);
      end
    end
  end

  // slots freed at frame start
  always_comb begin
    drop  = valid_r & mark_r;
    freed = '0;
    for (int s = 0; s < SLOTS; s++) begin
      freed = freed + 4'(drop[s]);
    end
  end

  // table write decode
  always_comb begin
    rect_we = 1'b0;
    attr_we = 1'b0;
    wa      = tgt;
    if (issue && cmd.op == OP_ADD && found) begin
      rect_we = 1'b1;
      attr_we = 1'b1;
      wa      = free_idx;
    end else if (issue && cmd.op == OP_MOVE && cmd.slot_ok && valid_r[tgt]) begin
      rect_we = 1'b1;
    end
  end

  // slot memories, registered reads at the current pair
  always_ff @(posedge clk) begin
    if (rect_we) begin
      rect_mem[wa] <= cmd.rect;
    end
    if (attr_we) begin
      attr_mem[wa] <= cmd.attr;
    end
    rect_a_r <= rect_mem[i_r];
    rect_b_r <= rect_mem[k_r];
    attr_a_r <= attr_mem[i_r];
    attr_b_r <= attr_mem[k_r];
  end

  // overlap test, touching edges count
  always_comb begin
    a_l = 18'(rect_a_r.x);
    a_t = 18'(rect_a_r.y);
    b_l = 18'(rect_b_r.x);
    b_t = 18'(rect_b_r.y);
    a_r = a_l + $signed({3'b0, rect_a_r.w});
    a_b = a_t + $signed({3'b0, rect_a_r.h});
    b_r = b_l + $signed({3'b0, rect_b_r.w});
    b_b = b_t + $signed({3'b0, rect_b_r.h});
    ov  = !(b_l > a_r || b_r < a_l || b_t > a_b || b_b < a_t);
    rep_a = ov && attr_a_r.lis && mask_bit(mask_low, mask_high, attr_a_r.kind, attr_b_r.kind);
    rep_b = ov && attr_b_r.lis && mask_bit(mask_low, mask_high, attr_b_r.kind, attr_a_r.kind);
  end

  assign pair_end = (k_r == LAST_IDX);
  assign cmd_pop  = (issue && cmd.op != OP_TICK) || (state_r == S_DONE && out_free);

  // control sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      mark_r   <= '0;
      count_r  <= '0;
      i_r      <= '0;
      k_r      <= '0;
      ovalid_r <= 1'b0;
      kind_r   <= RK_ACK;
      self_r   <= '0;
      other_r  <= '0;
      live_r   <= '0;
      last_r   <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (issue) begin
            unique case (cmd.op)
              OP_ADD: begin
                ovalid_r <= 1'b1;
                last_r   <= 1'b1;
                other_r  <= '0;
                if (found) begin
                  valid_r[free_idx] <= 1'b1;
                  mark_r[free_idx]  <= 1'b0;
                  count_r  <= count_r + 4'd1;
                  live_r   <= count_r + 4'd1;
                  kind_r   <= RK_ADDED;
                  self_r   <= 3'(free_idx);
                end else begin
                  live_r   <= count_r;
                  kind_r   <= RK_FULL;
                  self_r   <= '0;
                end
              end
              OP_MOVE, OP_MARK: begin
                if (cmd.op == OP_MARK && cmd.slot_ok && valid_r[tgt]) begin
                  mark_r[tgt] <= 1'b1;
                end
                ovalid_r <= 1'b1;
                last_r   <= 1'b1;
                kind_r   <= RK_ACK;
                self_r   <= cmd.slot;
                other_r  <= '0;
                live_r   <= count_r;
              end
              OP_TICK: begin
                valid_r <= valid_r & ~drop;
                mark_r  <= mark_r & ~drop;
                count_r <= count_r - freed;
                i_r     <= '0;
                k_r     <= IW'(1);
                state_r <= S_FETCH;
              end
              default: ;
            endcase
          end
        end
        S_FETCH: begin
          if (i_r == LAST_IDX) begin
            state_r <= S_DONE;
          end else if (valid_r[i_r] && valid_r[k_r]) begin
            state_r <= S_EVAL;
          end else if (pair_end) begin
            i_r <= i_r + IW'(1);
            k_r <= i_r + IW'(2);
          end else begin
            k_r <= k_r + IW'(1);
          end
        end
        S_EVAL: begin
          if (!(rep_a || rep_b) || out_free) begin
            if (rep_a || rep_b) begin
              ovalid_r <= 1'b1;
              kind_r   <= RK_HIT;
              last_r   <= 1'b0;
              live_r   <= count_r;
              self_r   <= rep_a ? 3'(i_r) : 3'(k_r);
              other_r  <= rep_a ? 3'(k_r) : 3'(i_r);
            end
            if (rep_a && rep_b) begin
              state_r <= S_SECOND;
            end else begin
              state_r <= S_FETCH;
              if (pair_end) begin
                i_r <= i_r + IW'(1);
                k_r <= i_r + IW'(2);
              end else begin
                k_r <= k_r + IW'(1);
              end
            end
          end
        end
        S_SECOND: begin
          if (out_free) begin
            ovalid_r <= 1'b1;
            kind_r   <= RK_HIT;
            last_r   <= 1'b0;
            live_r   <= count_r;
            self_r   <= 3'(k_r);
            other_r  <= 3'(i_r);
            state_r  <= S_FETCH;
            if (pair_end) begin
              i_r <= i_r + IW'(1);
              k_r <= i_r + IW'(2);
            end else begin
              k_r <= k_r + IW'(1);
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            ovalid_r <= 1'b1;
            kind_r   <= RK_DONE;
            last_r   <= 1'b1;
            live_r   <= count_r;
            self_r   <= '0;
            other_r  <= '0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: bench/tb.sv
// tb: self-checking bench for the rectangle collision pair scanner
module tb;
  import rcps_pkg::*;

  localparam int NSLOT = 8;
  localparam int WATCHDOG = 20000;
  localparam logic [3:0] ADDR_MASK_LO = 4'd0;
  localparam logic [3:0] ADDR_MASK_HI = 4'd8;

  typedef struct packed {
    opcode_t            op;
    logic [2:0]         slot;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
    logic [3:0]         kind;
    logic               lis;
  } cmd_beat_t;

  typedef struct packed {
    result_kind_t kind;
    logic [2:0]   self_slot;
    logic [2:0]   other_slot;
    logic [3:0]   live;
    logic         last;
  } res_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  rcps_in_if  in_ch();
  rcps_out_if out_ch();

  rect_collision_pair_scanner #(.SLOTS(NSLOT)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // shadow of the slot table and mask registers
  logic [49:0] mask_lo, mask_hi;
  logic        sh_valid [NSLOT];
  logic        sh_mark  [NSLOT];
  logic        sh_lis   [NSLOT];
  logic [3:0]  sh_kind  [NSLOT];
  logic signed [15:0] sh_x [NSLOT], sh_y [NSLOT];
  logic [14:0] sh_w [NSLOT], sh_h [NSLOT];
  logic [3:0]  sh_live;

  cmd_beat_t pending_cmds[$];
  res_beat_t expected_results[$];
  int send_idle_pct = 38, recv_idle_pct = 62;
  int errors = 0;
  int quiet_cycles = 0;
  bit in_fire = 1'b0;
  bit out_fire = 1'b0;

  function automatic logic mask_hit(logic [3:0] row, logic [3:0] col);
    if (row > 9 || col > 9) return 1'b0;
    if (row < 5) return mask_lo[row * 10 + col];
    return mask_hi[(row - 5) * 10 + col];
  endfunction

  function automatic logic rects_touch(int a, int b);
    int ax, ay, aw, ah, bx, by, bw, bh;
    ax = sh_x[a]; ay = sh_y[a]; aw = sh_w[a]; ah = sh_h[a];
    bx = sh_x[b]; by = sh_y[b]; bw = sh_w[b]; bh = sh_h[b];
    return !(bx > ax + aw || bx + bw < ax || by > ay + ah || by + bh < ay);
  endfunction

  function automatic res_beat_t mk_res(result_kind_t k, int s, int o, logic l);
    res_beat_t r;
    r.kind = k; r.self_slot = 3'(s); r.other_slot = 3'(o);
    r.live = sh_live; r.last = l;
    return r;
  endfunction

  // compute result beats for one accepted command
  task automatic predict_table_op(cmd_beat_t c);
    int fs;
    fs = -1;
    case (c.op)
      OP_ADD: begin
        for (int i = NSLOT - 1; i >= 0; i--) if (!sh_valid[i]) fs = i;
        if (fs < 0) begin
          expected_results.push_back(mk_res(RK_FULL, 0, 0, 1'b1));
        end else begin
          sh_valid[fs] = 1'b1; sh_mark[fs] = 1'b0;
          sh_x[fs] = c.x; sh_y[fs] = c.y; sh_w[fs] = c.w; sh_h[fs] = c.h;
          sh_kind[fs] = c.kind; sh_lis[fs] = c.lis;
          sh_live++;
          expected_results.push_back(mk_res(RK_ADDED, fs, 0, 1'b1));
        end
      end
      OP_MOVE, OP_MARK: begin
        if (sh_valid[c.slot]) begin
          if (c.op == OP_MOVE) begin
            sh_x[c.slot] = c.x; sh_y[c.slot] = c.y;
            sh_w[c.slot] = c.w; sh_h[c.slot] = c.h;
          end else begin
            sh_mark[c.slot] = 1'b1;
          end
        end
        expected_results.push_back(mk_res(RK_ACK, c.slot, 0, 1'b1));
      end
      default: begin
        for (int i = 0; i < NSLOT; i++)
          if (sh_valid[i] && sh_mark[i]) begin
            sh_valid[i] = 1'b0; sh_mark[i] = 1'b0;
            if (sh_live > 0) sh_live--;
          end
        for (int i = 0; i < NSLOT; i++) begin
          if (!sh_valid[i]) continue;
          for (int k = i + 1; k < NSLOT; k++) begin
            if (!sh_valid[k] || !rects_touch(i, k)) continue;
            if (sh_lis[i] && mask_hit(sh_kind[i], sh_kind[k]))
              expected_results.push_back(mk_res(RK_HIT, i, k, 1'b0));
            if (sh_lis[k] && mask_hit(sh_kind[k], sh_kind[i]))
              expected_results.push_back(mk_res(RK_HIT, k, i, 1'b0));
          end
        end
        expected_results.push_back(mk_res(RK_DONE, 0, 0, 1'b1));
      end
    endcase
  endtask

  // input driver: new beat or idle at the falling edge
  initial begin
    in_ch.valid = 1'b0; in_ch.opcode = '0; in_ch.slot = '0; in_ch.rect_x = '0;
    in_ch.rect_y = '0; in_ch.rect_w = '0; in_ch.rect_h = '0;
    in_ch.rect_class = '0; in_ch.has_listener = 1'b0;
    out_ch.ready = 1'b0;
  end

  // a beat is held until the rising edge that accepts it
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_fire)) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.opcode <= pending_cmds[0].op;
        in_ch.slot <= pending_cmds[0].slot;
        in_ch.rect_x <= pending_cmds[0].x;
        in_ch.rect_y <= pending_cmds[0].y;
        in_ch.rect_w <= pending_cmds[0].w;
        in_ch.rect_h <= pending_cmds[0].h;
        in_ch.rect_class <= pending_cmds[0].kind;
        in_ch.has_listener <= pending_cmds[0].lis;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    if (rst_n) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: predict on input beats, check result beats
  always @(posedge clk) begin
    if (rst_n) begin
      in_fire  = in_ch.valid && in_ch.ready;
      out_fire = out_ch.valid && out_ch.ready;
      if (in_fire || out_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (in_fire) begin
        predict_table_op(pending_cmds.pop_front());
      end
      if (out_fire) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected beat kind=%0d self=%0d other=%0d live=%0d last=%0d",
                   $time, out_ch.result_kind, out_ch.self_slot, out_ch.other_slot,
                   out_ch.live_count, out_ch.last);
          errors++;
        end else begin
          res_beat_t e;
          e = expected_results.pop_front();
          if (out_ch.result_kind !== e.kind || out_ch.self_slot !== e.self_slot ||
              out_ch.other_slot !== e.other_slot || out_ch.live_count !== e.live ||
              out_ch.last !== e.last) begin
            $display("%0t: mismatch expected kind=%0d self=%0d other=%0d live=%0d last=%0d",
                     $time, e.kind, e.self_slot, e.other_slot, e.live, e.last);
            $display("%0t:          actual   kind=%0d self=%0d other=%0d live=%0d last=%0d",
                     $time, out_ch.result_kind, out_ch.self_slot, out_ch.other_slot,
                     out_ch.live_count, out_ch.last);
            errors++;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  function automatic cmd_beat_t rnd_cmd(opcode_t op, bit clustered);
    cmd_beat_t c;
    c.op = op;
    c.slot = 3'($urandom_range(7));
    if (clustered) begin
      c.x = 16'($signed($urandom_range(200)) - 100);
      c.y = 16'($signed($urandom_range(200)) - 100);
      c.w = 15'($urandom_range(80));
      c.h = 15'($urandom_range(80));
    end else begin
      c.x = 16'($urandom); c.y = 16'($urandom);
      c.w = 15'($urandom); c.h = 15'($urandom);
    end
    c.kind = 4'($urandom_range(99) < 90 ? $urandom_range(9) : $urandom_range(15));
    c.lis = 1'($urandom_range(99) < 75);
    return c;
  endfunction

  function automatic cmd_beat_t fixed_cmd(opcode_t op, int s, int x, int y, int w, int h,
                                          int k, bit l);
    cmd_beat_t c;
    c.op = op; c.slot = 3'(s); c.x = 16'(x); c.y = 16'(y);
    c.w = 15'(w); c.h = 15'(h); c.kind = 4'(k); c.lis = l;
    return c;
  endfunction

  // wait until all queued beats are in and every expected result is out
  task automatic drain();
    wait (pending_cmds.size() == 0 && expected_results.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic apb_write(logic [3:0] addr, logic [63:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= addr; cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic set_masks(logic [49:0] lo, logic [49:0] hi);
    apb_write(ADDR_MASK_LO, {14'd0, lo});
    apb_write(ADDR_MASK_HI, {14'd0, hi});
    mask_lo = lo; mask_hi = hi;
  endtask

  // a frame: some adds, moves, marks, then a tick
  task automatic queue_frame(bit clustered);
    int n;
    n = $urandom_range(6);
    for (int j = 0; j < n; j++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: pending_cmds.push_back(rnd_cmd(OP_ADD, clustered));
        4, 5, 6:    pending_cmds.push_back(rnd_cmd(OP_MOVE, clustered));
        default:    pending_cmds.push_back(rnd_cmd(OP_MARK, clustered));
      endcase
    end
    pending_cmds.push_back(rnd_cmd(OP_TICK, clustered));
  endtask

  initial begin
    int sent;
    mask_lo = '0; mask_hi = '0; sh_live = '0;
    for (int i = 0; i < NSLOT; i++) begin
      sh_valid[i] = 1'b0; sh_mark[i] = 1'b0; sh_lis[i] = 1'b0; sh_kind[i] = '0;
      sh_x[i] = '0; sh_y[i] = '0; sh_w[i] = '0; sh_h[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: full mask, extremes, table full, touching edges, odd types
    set_masks({50{1'b1}}, {50{1'b1}});
    pending_cmds.push_back(fixed_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(fixed_cmd(OP_ADD, 0, -32768, -32768, 32767, 32767, 0, 1));
    pending_cmds.push_back(fixed_cmd(OP_ADD, 0, 32767, 32767, 0, 0, 9, 1));
    pending_cmds.push_back(fixed_cmd(OP_ADD, 0, -1, -1, 0, 0, 15, 1));
    pending_cmds.push_back(fixed_cmd(OP_ADD, 7, 10, 10, 5, 5, 1, 0));
    pending_cmds.push_back(fixed_cmd(OP_ADD, 0, 15, 15, 5, 5, 2, 1));
    pending_cmds.push_back(fixed_cmd(OP_ADD, 0, 20, 21, 3, 3, 5, 1));
    pending_cmds.push_back(fixed_cmd(OP_ADD, 0, 0, 0, 100, 100, 7, 1));
    pending_cmds.push_back(fixed_cmd(OP_ADD, 0, 5, 5, 1, 1, 10, 1));
    pending_cmds.push_back(fixed_cmd(OP_ADD, 0, 0, 0, 1, 1, 3, 1));
    pending_cmds.push_back(fixed_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(fixed_cmd(OP_MOVE, 2, 30000, -30000, 1, 1, 4, 0));
    pending_cmds.push_back(fixed_cmd(OP_MARK, 3, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(fixed_cmd(OP_MARK, 3, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(fixed_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(fixed_cmd(OP_MOVE, 3, 1, 1, 1, 1, 0, 0));
    pending_cmds.push_back(fixed_cmd(OP_MARK, 3, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(fixed_cmd(OP_ADD, 0, 1, 2, 3, 4, 6, 1));
    pending_cmds.push_back(fixed_cmd(OP_MARK, 3, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(fixed_cmd(OP_ADD, 0, 1, 2, 3, 4, 8, 1));
    pending_cmds.push_back(fixed_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // random, sweeping mask settings and idling profiles
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_masks('0, '0);
        1: set_masks(50'($urandom) | (50'($urandom) << 32), 50'($urandom) << 18);
        2: begin set_masks({50{1'b1}}, '0); send_idle_pct = 62; recv_idle_pct = 38; end
        3: set_masks('0, {50{1'b1}});
        4: begin
          set_masks(50'($urandom) ^ (50'($urandom) << 20), 50'($urandom) | (50'($urandom) << 25));
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        default: set_masks({50{1'b1}}, {50{1'b1}});
      endcase
      while (sent < (ph + 1) * 26) begin
        int prev_len;
        prev_len = pending_cmds.size();
        queue_frame($urandom_range(99) < 85);
        if ($urandom_range(99) < 10)
          pending_cmds.push_back(rnd_cmd(opcode_t'($urandom_range(3)), 1'b0));
        sent += pending_cmds.size() - prev_len;
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: rect_collision_pair_scanner.f
design/rcps_pkg.sv
design/rcps_if.sv
design/rcps_front.sv
design/rcps_cmdq.sv
design/rcps_back.sv
design/rect_collision_pair_scanner.sv
bench/tb.sv
